>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int MaxTasks = 64;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CountW   = $clog2(MaxTasks + 1);
  localparam int PrioW    = 6;
  localparam int DelayW   = 32;
  localparam int TickW    = 32;
  localparam int RunW     = 6;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxTasks);
  localparam logic [PrioW-1:0]  IdlePrio = 6'd63;

  typedef enum logic [1:0] {
    KindAdd   = 2'd0,
    KindTick  = 2'd1,
    KindDelay = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TaskReady   = 2'd0,
    TaskRunning = 2'd1,
    TaskPending = 2'd2
  } task_st_e;

  // controller -> datapath
  typedef struct packed {
    logic init;    // write the idle task into entry 0
    logic accept;  // request taken this cycle
    logic issue;   // read the next table entry
    logic finish;  // mark the winner running
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic issue_last;  // entry being read is the last one in use
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/pts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [1:0]   kind_i,
  input  wire pts_pkg::stat_t stat_i,
  output pts_pkg::cmd_t     cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    cmd_o        = '0;
    cmd_o.init   = (state_q == StInit);
    cmd_o.accept = accept;
    cmd_o.issue  = (state_q == StScan);
    cmd_o.finish = (state_q == StFinish);
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      StInit: begin
        state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          case (pts_pkg::kind_e'(kind_i))
            pts_pkg::KindTick,
            pts_pkg::KindDelay: state_d = StScan;
            default:            done_d  = 1'b1;
          endcase
        end
      end
      StScan: begin
        if (stat_i.issue_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        state_d = StIdle;
        done_d  = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/pts_data.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_data (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pts_pkg::cmd_t                cmd_i,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [pts_pkg::PrioW-1:0]    priority_req_i,
  input  wire logic [pts_pkg::DelayW-1:0]   delay_ticks_i,
  output pts_pkg::stat_t                    stat_o,
  output logic [pts_pkg::RunW-1:0]          run_index_o,
  output logic                              switch_request_o,
  output logic                              status_o,
  output logic [pts_pkg::TickW-1:0]         tick_count_o
);

  localparam int IdxW   = pts_pkg::IdxW;
  localparam int CountW = pts_pkg::CountW;
  localparam int PrioW  = pts_pkg::PrioW;
  localparam int DelayW = pts_pkg::DelayW;
  localparam int RunW   = pts_pkg::RunW;

  // task table
  logic [1:0]        status_mem [pts_pkg::MaxTasks];
  logic [PrioW-1:0]  prio_mem   [pts_pkg::MaxTasks];
  logic [DelayW-1:0] delay_mem  [pts_pkg::MaxTasks];

  logic [1:0]        st_rd_q;
  logic [PrioW-1:0]  prio_rd_q;
  logic [DelayW-1:0] dly_rd_q;

  logic [CountW-1:0]        count_q, count_d;
  logic [IdxW-1:0]          next_idx_q, next_idx_d;
  logic [pts_pkg::TickW-1:0] tick_q, tick_d;
  logic [CountW-1:0]        iss_q, iss_d;
  logic                     rd_valid_q;
  logic [IdxW-1:0]          proc_idx_q;
  logic [IdxW-1:0]          best_idx_q, best_idx_d;
  logic [PrioW-1:0]         best_prio_q, best_prio_d;
  logic                     op_delay_q;
  logic [DelayW-1:0]        dly_q;
  logic                     sw_q;
  logic                     st_q;

  logic full;
  logic add_ok;
  logic sched;
  pts_pkg::kind_e kind;

  // scan step for the entry that came out of the table
  pts_pkg::task_st_e st_eff, st_new;
  logic [DelayW-1:0] dl_eff, dl_new;
  logic              win;

  // write ports
  logic              st_we, pr_we, dl_we;
  logic [IdxW-1:0]   st_wa, tb_wa;
  logic [1:0]        st_wd;
  logic [PrioW-1:0]  pr_wd;
  logic [DelayW-1:0] dl_wd;
  logic [IdxW-1:0]   rd_addr;

  logic [IdxW+RunW-1:0] run_ext;

  assign kind   = pts_pkg::kind_e'(kind_i);
  assign full   = (count_q == pts_pkg::MaxCount);
  assign add_ok = cmd_i.accept && (kind == pts_pkg::KindAdd) && !full;
  assign sched  = cmd_i.accept && ((kind == pts_pkg::KindTick) || (kind == pts_pkg::KindDelay));
  assign rd_addr = iss_q[IdxW-1:0];

  assign stat_o.issue_last = (iss_q == (count_q - CountW'(1)));

  always_comb begin
    st_eff = pts_pkg::task_st_e'(st_rd_q);
    dl_eff = dly_rd_q;
    // release the running task, or pend it for a delay request
    if (proc_idx_q == next_idx_q) begin
      if (op_delay_q) begin
        st_eff = pts_pkg::TaskPending;
        dl_eff = dly_q;
      end else if (st_eff == pts_pkg::TaskRunning) begin
        st_eff = pts_pkg::TaskReady;
      end
    end
    if (dl_eff == '0) begin
      st_new = pts_pkg::TaskReady;
      dl_new = dl_eff;
    end else begin
      st_new = st_eff;
      dl_new = dl_eff - DelayW'(1);
    end
    win = (st_new == pts_pkg::TaskReady) && (prio_rd_q < best_prio_q);
  end

  always_comb begin
    st_we = 1'b0;
    pr_we = 1'b0;
    dl_we = 1'b0;
    st_wa = proc_idx_q;
    tb_wa = proc_idx_q;
    st_wd = st_new;
    pr_wd = priority_req_i;
    dl_wd = dl_new;
    if (cmd_i.init) begin
      st_we = 1'b1;
      pr_we = 1'b1;
      dl_we = 1'b1;
      st_wa = '0;
      tb_wa = '0;
      st_wd = pts_pkg::TaskRunning;
      pr_wd = pts_pkg::IdlePrio;
      dl_wd = '0;
    end else if (add_ok) begin
      st_we = 1'b1;
      pr_we = 1'b1;
      dl_we = 1'b1;
      st_wa = count_q[IdxW-1:0];
      tb_wa = count_q[IdxW-1:0];
      st_wd = pts_pkg::TaskReady;
      dl_wd = '0;
    end else if (cmd_i.finish) begin
      st_we = 1'b1;
      st_wa = best_idx_q;
      st_wd = pts_pkg::TaskRunning;
    end else if (rd_valid_q) begin
      st_we = 1'b1;
      dl_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      status_mem[st_wa] <= st_wd;
    end
    if (pr_we) begin
      prio_mem[tb_wa] <= pr_wd;
    end
    if (dl_we) begin
      delay_mem[tb_wa] <= dl_wd;
    end
    st_rd_q   <= status_mem[rd_addr];
    prio_rd_q <= prio_mem[rd_addr];
    dly_rd_q  <= delay_mem[rd_addr];
  end

  always_comb begin
    count_d     = count_q;
    next_idx_d  = next_idx_q;
    tick_d      = tick_q;
    iss_d       = iss_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    if (add_ok) begin
      count_d = count_q + CountW'(1);
    end
    if (sched) begin
      iss_d       = '0;
      best_idx_d  = '0;
      best_prio_d = pts_pkg::IdlePrio;
      if (kind == pts_pkg::KindTick) begin
        tick_d = tick_q + pts_pkg::TickW'(1);
      end
    end
    if (cmd_i.issue) begin
      iss_d = iss_q + CountW'(1);
    end
    if (rd_valid_q && win) begin
      best_idx_d  = proc_idx_q;
      best_prio_d = prio_rd_q;
    end
    if (cmd_i.finish) begin
      next_idx_d = best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CountW'(1);
      next_idx_q <= '0;
      tick_q     <= '0;
      iss_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      next_idx_q <= next_idx_d;
      tick_q     <= tick_d;
      iss_q      <= iss_d;
      rd_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q  <= rd_addr;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    if (cmd_i.accept) begin
      op_delay_q <= (kind == pts_pkg::KindDelay);
      dly_q      <= delay_ticks_i;
      sw_q       <= sched;
      st_q       <= (kind == pts_pkg::KindAdd) && full;
    end
  end

  assign run_ext          = {{RunW{1'b0}}, next_idx_q};
  assign run_index_o      = run_ext[RunW-1:0];
  assign switch_request_o = sw_q;
  assign status_o         = st_q;
  assign tick_count_o     = tick_q;

endmodule

`default_nettype wire

>>> rtl/priority_task_scheduler.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// request   | kind_i, priority_req_i, delay_ticks_i              | start_i high, busy_o low
// result    | run_index_o, switch_request_o, status_o,           | done_o high for one cycle
//           | tick_count_o                                       |
//
// An add or an unused kind gives its result on the next cycle. A tick or delay scans the
// task table through one memory read port, one entry a cycle, then drains the last read
// and marks the winner running before it gives its result.
// After reset the block writes the idle task into entry 0 before it takes a request.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_scheduler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [pts_pkg::PrioW-1:0]    priority_req_i,
  input  wire logic [pts_pkg::DelayW-1:0]   delay_ticks_i,
  output logic                              done_o,
  output logic [pts_pkg::RunW-1:0]          run_index_o,
  output logic                              switch_request_o,
  output logic                              status_o,
  output logic [pts_pkg::TickW-1:0]         tick_count_o
);

  pts_pkg::cmd_t  cmd;
  pts_pkg::stat_t stat;

  pts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  pts_data u_data (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .priority_req_i   (priority_req_i),
    .delay_ticks_i    (delay_ticks_i),
    .stat_o           (stat),
    .run_index_o      (run_index_o),
    .switch_request_o (switch_request_o),
    .status_o         (status_o),
    .tick_count_o     (tick_count_o)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import pts_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned RandomRequests = 1500;
  localparam int unsigned SteadyTail = 200;
  localparam int unsigned DrainCycles = MaxTasks + 8;

  typedef struct packed {
    logic [RunW-1:0]  run_index;
    logic             switch_request;
    logic             status;
    logic [TickW-1:0] tick_count;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PrioW-1:0]  prio;
    logic [DelayW-1:0] delay;
    logic              typed;
    sched_result_t     want;
  } request_row_t;

  localparam int NumRows = 18;

  // Typed rows: after reset, idle-task delay cases, a first preemption.
  localparam request_row_t DirectedRows [NumRows] = '{
    '{KindTick,   6'd0,  32'h0000_0000, 1'b1, '{6'd0, 1'b1, 1'b0, 32'd1}},
    '{KindUnused, 6'd63, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0, 32'd1}},
    '{KindDelay,  6'd0,  32'h0000_0000, 1'b1, '{6'd0, 1'b1, 1'b0, 32'd1}},
    '{KindDelay,  6'd0,  32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b1, 1'b0, 32'd1}},
    '{KindAdd,    6'd0,  32'hAAAA_AAAA, 1'b1, '{6'd0, 1'b0, 1'b0, 32'd1}},
    '{KindAdd,    6'd63, 32'h5555_5555, 1'b1, '{6'd0, 1'b0, 1'b0, 32'd1}},
    '{KindTick,   6'd0,  32'h0000_0000, 1'b1, '{6'd1, 1'b1, 1'b0, 32'd2}},
    '{KindDelay,  6'd0,  32'hFFFF_FFFF, 1'b0, '0},
    '{KindAdd,    6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindTick,   6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindDelay,  6'd0,  32'h0000_0001, 1'b0, '0},
    '{KindTick,   6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindTick,   6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindAdd,    6'd42, 32'h0000_0000, 1'b0, '0},
    '{KindDelay,  6'd0,  32'h0000_0002, 1'b0, '0},
    '{KindUnused, 6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindTick,   6'd0,  32'h0000_0000, 1'b0, '0},
    '{KindDelay,  6'd0,  32'h0000_0000, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        kind_i;
  logic [PrioW-1:0]  priority_req_i;
  logic [DelayW-1:0] delay_ticks_i;
  logic              done_o;
  logic [RunW-1:0]   run_index_o;
  logic              switch_request_o;
  logic              status_o;
  logic [TickW-1:0]  tick_count_o;

  priority_task_scheduler dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .kind_i,
    .priority_req_i,
    .delay_ticks_i,
    .done_o,
    .run_index_o,
    .switch_request_o,
    .status_o,
    .tick_count_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Scheduler shadow state
  task_st_e          sched_status [MaxTasks];
  logic [PrioW-1:0]  sched_prio   [MaxTasks];
  logic [DelayW-1:0] sched_delay  [MaxTasks];
  int unsigned       sched_count;
  int unsigned       sched_next;
  logic [TickW-1:0]  sched_ticks;

  sched_result_t decisions_q [$];
  int unsigned   mismatches;
  bit            pauses_on;

  function automatic void pick_next_task();
    int unsigned best;
    best = 0;
    // release the running task, then walk the table
    if (sched_status[sched_next] == TaskRunning) sched_status[sched_next] = TaskReady;
    for (int unsigned i = 0; i < sched_count; i++) begin
      if (sched_delay[i] == '0) sched_status[i] = TaskReady;
      else sched_delay[i] = sched_delay[i] - 1'b1;
      if (sched_status[i] == TaskReady && sched_prio[i] < sched_prio[best]) best = i;
    end
    sched_next = best;
    sched_status[best] = TaskRunning;
  endfunction

  function automatic sched_result_t apply_request(input logic [1:0] kind,
                                                  input logic [PrioW-1:0] prio,
                                                  input logic [DelayW-1:0] dly);
    sched_result_t res;
    res = '0;
    case (kind)
      KindAdd: begin
        if (sched_count >= MaxTasks) begin
          res.status = 1'b1;
        end else begin
          sched_status[sched_count] = TaskReady;
          sched_prio[sched_count] = prio;
          sched_delay[sched_count] = '0;
          sched_count++;
        end
      end
      KindTick: begin
        sched_ticks = sched_ticks + 1'b1;
        pick_next_task();
        res.switch_request = 1'b1;
      end
      KindDelay: begin
        sched_delay[sched_next] = dly;
        sched_status[sched_next] = TaskPending;
        pick_next_task();
        res.switch_request = 1'b1;
      end
      default: ;
    endcase
    res.run_index = sched_next[RunW-1:0];
    res.tick_count = sched_ticks;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input logic [1:0] kind, input logic [PrioW-1:0] prio,
                               input logic [DelayW-1:0] dly, input logic typed,
                               input sched_result_t want);
    sched_result_t predicted;
    start_i <= 1'b1;
    kind_i <= kind;
    priority_req_i <= prio;
    delay_ticks_i <= dly;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = apply_request(kind, prio, dly);
    decisions_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  function automatic logic [DelayW-1:0] pick_delay();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return DelayW'($urandom_range(0, 3));
    if (sel < 90) return DelayW'($urandom_range(4, 24));
    if (sel < 95) return DelayW'($urandom_range(25, 200));
    if (sel < 97) return $urandom();
    if (sel < 98) return 32'hFFFF_FFFF;
    return 32'h8000_0000;
  endfunction

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (decisions_q.size() == 0) begin
        $error("unexpected result: run_index %0d tick_count %0d",
               run_index_o, tick_count_o);
        mismatches++;
      end else begin
        want = decisions_q.pop_front();
        if (run_index_o !== want.run_index) begin
          $error("run_index: expected %0d, got %0d", want.run_index, run_index_o);
          mismatches++;
        end
        if (switch_request_o !== want.switch_request) begin
          $error("switch_request: expected %0b, got %0b",
                 want.switch_request, switch_request_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, status_o);
          mismatches++;
        end
        if (tick_count_o !== want.tick_count) begin
          $error("tick_count: expected %0d, got %0d", want.tick_count, tick_count_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [1:0]        kind;
    logic [PrioW-1:0]  prio;
    logic [DelayW-1:0] dly;
    int unsigned       sel;
    int unsigned       counted;

    rst_ni = 1'b0;
    start_i = 1'b0;
    kind_i = KindAdd;
    priority_req_i = '0;
    delay_ticks_i = '0;
    mismatches = 0;
    pauses_on = 1'b1;
    counted = 0;
    for (int i = 0; i < MaxTasks; i++) begin
      sched_status[i] = TaskReady;
      sched_prio[i] = '0;
      sched_delay[i] = '0;
    end
    sched_status[0] = TaskRunning;
    sched_prio[0] = IdlePrio;
    sched_count = 1;
    sched_next = 0;
    sched_ticks = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[r]) begin
      maybe_pause();
      issue_request(DirectedRows[r].kind, DirectedRows[r].prio, DirectedRows[r].delay,
                    DirectedRows[r].typed, DirectedRows[r].want);
    end

    // Adds are rare enough that the table fills about halfway through.
    while (counted < RandomRequests) begin
      if (counted % 64 == 0) pauses_on = ($urandom_range(0, 2) != 0);
      if (counted >= RandomRequests - SteadyTail) pauses_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 8) kind = KindAdd;
      else if (sel < 52) kind = KindTick;
      else if (sel < 94) kind = KindDelay;
      else kind = KindUnused;
      prio = $urandom_range(0, 63);
      dly = (kind == KindDelay) ? pick_delay() : $urandom();
      maybe_pause();
      issue_request(kind, prio, dly, 1'b0, '0);
      if (kind != KindUnused) counted++;
    end
    start_i <= 1'b0;

    while (decisions_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && decisions_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
